// File: rtl/pwfs_pkg.sv
package pwfs_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [3:0] VarintMaxBytes = 4'd10;

  typedef enum logic [2:0] {
    K_VARINT    = 3'd0,
    K_FIXED64   = 3'd1,
    K_LENGTH    = 3'd2,
    K_FIXED32   = 3'd3,
    K_PAYLOAD   = 3'd4,
    K_CLEAN_END = 3'd5,
    K_TRUNC_END = 3'd6,
    K_ABORTED   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VALUE,
    PH_FIXED,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic        truncated;
    logic        end_of_buffer;
  } out_item_t;

  // One byte's worth of results: the first is always present, the second optional.
  typedef struct packed {
    out_item_t first;
    logic      second_valid;
    out_item_t second;
  } rec_t;

endpackage

// File: rtl/pwfs_front.sv
module pwfs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  pwfs_pkg::in_item_t in_item,
  input  logic               emit_payload,
  output logic               rec_push,
  output pwfs_pkg::rec_t     rec
);
  import pwfs_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [31:0] fn_r, fn_nxt;
  logic [2:0]  wt_r, wt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        aborted_r, aborted_nxt;

  logic [7:0]  b;
  logic        last;
  logic [6:0]  shift7;
  logic [63:0] var_acc;
  logic [63:0] fix_acc;
  logic [3:0]  var_bc;
  logic        var_done;
  logic        var_over;
  logic [3:0]  fix_need;

  logic        step_v;
  out_item_t   step_res;
  logic        abort_now;
  logic [31:0] ab_fn;
  logic [2:0]  ab_wt;
  out_item_t   end_res;
  out_item_t   part_res;
  logic        part_v;
  logic        clear;

  assign b        = in_item.data_byte;
  assign last     = in_item.last_byte;
  assign shift7   = 7'({3'b000, bc_r} * 7'd7);
  assign var_acc  = acc_r | (64'(b[6:0]) << shift7);
  assign fix_acc  = acc_r | (64'(b) << {bc_r[2:0], 3'b000});
  assign var_bc   = bc_r + 4'd1;
  assign var_done = !b[7];
  assign var_over = !var_done && (var_bc >= VarintMaxBytes);
  assign fix_need = (wt_r == WT_FIXED64) ? 4'd8 : 4'd4;

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    bc_nxt      = bc_r;
    fn_nxt      = fn_r;
    wt_nxt      = wt_r;
    rem_nxt     = rem_r;
    aborted_nxt = aborted_r;
    step_v      = 1'b0;
    step_res    = '0;
    abort_now   = 1'b0;
    ab_fn       = '0;
    ab_wt       = '0;
    step_res.field_number = fn_r;
    step_res.wire_type    = wt_r;
    unique case (phase_r)
      PH_TAG: begin
        if (var_done) begin
          fn_nxt  = var_acc[34:3];
          wt_nxt  = var_acc[2:0];
          acc_nxt = '0;
          bc_nxt  = '0;
          unique case (var_acc[2:0])
            WT_VARINT: phase_nxt = PH_VALUE;
            WT_FIXED64, WT_FIXED32: phase_nxt = PH_FIXED;
            WT_LENGTH: phase_nxt = PH_LENGTH;
            default: begin
              abort_now = 1'b1;
              ab_fn     = var_acc[34:3];
              ab_wt     = var_acc[2:0];
            end
          endcase
        end else begin
          acc_nxt = var_acc;
          bc_nxt  = var_bc;
          if (var_over) begin
            abort_now = 1'b1;
          end
        end
      end
      PH_VALUE: begin
        if (var_done) begin
          step_v         = 1'b1;
          step_res.kind  = K_VARINT;
          step_res.value = var_acc;
          acc_nxt        = '0;
          bc_nxt         = '0;
          phase_nxt      = PH_TAG;
        end else begin
          acc_nxt = var_acc;
          bc_nxt  = var_bc;
          if (var_over) begin
            abort_now = 1'b1;
            ab_fn     = fn_r;
            ab_wt     = wt_r;
          end
        end
      end
      PH_FIXED: begin
        if (var_bc >= fix_need) begin
          step_v         = 1'b1;
          step_res.kind  = (fix_need == 4'd8) ? K_FIXED64 : K_FIXED32;
          step_res.value = fix_acc;
          acc_nxt        = '0;
          bc_nxt         = '0;
          phase_nxt      = PH_TAG;
        end else begin
          acc_nxt = fix_acc;
          bc_nxt  = var_bc;
        end
      end
      PH_LENGTH: begin
        if (var_done) begin
          step_v         = 1'b1;
          step_res.kind  = K_LENGTH;
          step_res.value = {32'd0, var_acc[31:0]};
          acc_nxt        = '0;
          bc_nxt         = '0;
          rem_nxt        = var_acc[31:0];
          phase_nxt      = (var_acc[31:0] == 32'd0) ? PH_TAG : PH_PAYLOAD;
        end else begin
          acc_nxt = var_acc;
          bc_nxt  = var_bc;
          if (var_over) begin
            abort_now = 1'b1;
            ab_fn     = fn_r;
            ab_wt     = wt_r;
          end
        end
      end
      PH_PAYLOAD: begin
        step_v         = emit_payload;
        step_res.kind  = K_PAYLOAD;
        step_res.value = 64'(b);
        if (rem_r != 32'd0) begin
          rem_nxt = rem_r - 32'd1;
        end
        if (rem_r <= 32'd1) begin
          phase_nxt = PH_TAG;
        end
      end
      default: begin
        phase_nxt = PH_TAG;
        acc_nxt   = '0;
        bc_nxt    = '0;
      end
    endcase
    if (abort_now) begin
      aborted_nxt = 1'b1;
      fn_nxt      = ab_fn;
      wt_nxt      = ab_wt;
    end
  end

  always_comb begin
    end_res  = '0;
    part_res = '0;
    part_v   = last && (phase_nxt == PH_VALUE);
    if (phase_nxt == PH_TAG && bc_nxt == 4'd0) begin
      end_res.kind = K_CLEAN_END;
    end else begin
      end_res.kind      = K_TRUNC_END;
      end_res.truncated = 1'b1;
      if (phase_nxt != PH_TAG) begin
        end_res.field_number = fn_nxt;
        end_res.wire_type    = wt_nxt;
      end
      if (phase_nxt == PH_PAYLOAD) begin
        end_res.value = {32'd0, rem_nxt};
      end
    end
    end_res.end_of_buffer = 1'b1;
    part_res.kind         = K_VARINT;
    part_res.field_number = fn_nxt;
    part_res.wire_type    = wt_nxt;
    part_res.value        = acc_nxt;
    part_res.truncated    = 1'b1;
  end

  always_comb begin
    rec      = '0;
    rec_push = 1'b0;
    clear    = last;
    if (aborted_r) begin
      rec.first.kind          = K_ABORTED;
      rec.first.field_number  = fn_r;
      rec.first.wire_type     = wt_r;
      rec.first.end_of_buffer = 1'b1;
      rec_push                = last;
    end else if (abort_now) begin
      rec.first.kind          = K_ABORTED;
      rec.first.field_number  = ab_fn;
      rec.first.wire_type     = ab_wt;
      rec.first.end_of_buffer = last;
      rec_push                = 1'b1;
    end else begin
      priority if (step_v) begin
        rec.first = step_res;
      end else if (part_v) begin
        rec.first = part_res;
      end else begin
        rec.first = end_res;
      end
      rec.second       = end_res;
      rec.second_valid = last && (step_v || part_v);
      rec_push         = step_v || last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG;
      acc_r     <= '0;
      bc_r      <= '0;
      fn_r      <= '0;
      wt_r      <= '0;
      rem_r     <= '0;
      aborted_r <= 1'b0;
    end else if (accept) begin
      if (clear) begin
        phase_r   <= PH_TAG;
        acc_r     <= '0;
        bc_r      <= '0;
        fn_r      <= '0;
        wt_r      <= '0;
        rem_r     <= '0;
        aborted_r <= 1'b0;
      end else if (!aborted_r) begin
        phase_r   <= phase_nxt;
        acc_r     <= acc_nxt;
        bc_r      <= bc_nxt;
        fn_r      <= fn_nxt;
        wt_r      <= wt_nxt;
        rem_r     <= rem_nxt;
        aborted_r <= aborted_nxt;
      end
    end
  end

endmodule

// File: rtl/pwfs_queue.sv
module pwfs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  pwfs_pkg::rec_t wr_rec,
  output logic           q_full,
  output logic           q_empty,
  input  logic           rd_en,
  output pwfs_pkg::rec_t rd_rec
);
  import pwfs_pkg::*;

  rec_t             mem_r [QDepth];
  logic [QPtrW-1:0] wp_r;
  logic [QPtrW-1:0] rp_r;
  logic [QCntW-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (cnt_r == QCntW'(QDepth));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_rec  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + QPtrW'(1);
      end
      if (do_rd) begin
        rp_r <= rp_r + QPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCntW'(1);
      end
    end
  end

endmodule

// File: rtl/pwfs_back.sv
module pwfs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  pwfs_pkg::rec_t      q_rec,
  output logic                q_pop,
  output pwfs_pkg::out_item_t res,
  output logic                res_valid,
  input  logic                res_take
);
  import pwfs_pkg::*;

  out_item_t out_r;
  logic      out_valid_r;
  out_item_t sec_r;
  logic      sec_valid_r;
  logic      slot_free;

  assign slot_free = !out_valid_r || res_take;
  assign q_pop     = slot_free && !sec_valid_r && !q_empty;
  assign res       = out_r;
  assign res_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (sec_valid_r) begin
        out_r <= sec_r;
      end else if (!q_empty) begin
        out_r <= q_rec.first;
        sec_r <= q_rec.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else if (!q_empty) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= q_rec.second_valid;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/protobuf_wire_field_scanner.sv
// Scans a protobuf wire-format buffer one byte per request and gives field
// results (tags with varint, fixed and length values, payload bytes) and an
// end result at the buffer's last byte. One byte is taken every clock cycle
// while the queue is not full; a result passes the queue, then the output
// register, which passes one result per cycle while results are taken. A
// byte with two results uses it twice; a four-entry queue between the byte
// decoder and the output stage absorbs that and any result-side stall.
// Register emit_payload (paddr[2] low) picks whether payload bytes go out;
// it should be written only while the block holds no work.
module protobuf_wire_field_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  pwfs_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output pwfs_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pwfs_pkg::*;

  logic      emit_payload_r;
  logic      accept;
  logic      rec_push;
  rec_t      rec;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  rec_t      q_rec;
  logic      res_valid;
  out_item_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, emit_payload_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_payload_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      emit_payload_r <= pwdata[0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  pwfs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_item      (in_data),
    .emit_payload (emit_payload_r),
    .rec_push     (rec_push),
    .rec          (rec)
  );

  pwfs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && rec_push),
    .wr_rec  (rec),
    .q_full  (q_full),
    .q_empty (q_empty),
    .rd_en   (q_pop),
    .rd_rec  (q_rec)
  );

  pwfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (pop)
  );

  assign empty    = !res_valid;
  assign out_data = res;

endmodule
